// ===== rtl/bst_pkg.sv =====
// Shared types, character codes and result codes for the bencode stream tokenizer.
package bst_pkg;

    typedef enum logic [1:0] {
        MODE_EXPECT,
        MODE_INT,
        MODE_STRLEN,
        MODE_BODY
    } mode_t;

    typedef enum logic [1:0] {
        CT_LIST,
        CT_DKEY,
        CT_DVAL,
        CT_NONE
    } ctype_t;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [2:0] KIND_INT    = 3'd0;
    localparam logic [2:0] KIND_STR    = 3'd1;
    localparam logic [2:0] KIND_LOPEN  = 3'd2;
    localparam logic [2:0] KIND_LCLOSE = 3'd3;
    localparam logic [2:0] KIND_DOPEN  = 3'd4;
    localparam logic [2:0] KIND_DCLOSE = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;
    localparam logic [2:0] KIND_DONE   = 3'd7;

    localparam logic [3:0] E_NONE      = 4'd0;
    localparam logic [3:0] E_BAD_INT   = 4'd1;
    localparam logic [3:0] E_BAD_LEN   = 4'd2;
    localparam logic [3:0] E_NO_COLON  = 4'd3;
    localparam logic [3:0] E_LEN_OVF   = 4'd4;
    localparam logic [3:0] E_BOUND     = 4'd5;
    localparam logic [3:0] E_KEY       = 4'd6;
    localparam logic [3:0] E_LIST_END  = 4'd7;
    localparam logic [3:0] E_DICT_END  = 4'd8;
    localparam logic [3:0] E_UNEXP_END = 4'd9;
    localparam logic [3:0] E_DEPTH     = 4'd10;

    localparam logic [2:0] CTX_NONE = 3'd0;
    localparam logic [2:0] CTX_INT  = 3'd1;
    localparam logic [2:0] CTX_STR  = 3'd2;
    localparam logic [2:0] CTX_LIST = 3'd3;
    localparam logic [2:0] CTX_DICT = 3'd4;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  code;
        logic [2:0]  ctx;
        logic [31:0] offset;
        logic [31:0] length;
        logic [4:0]  level;
        logic        last;
    } res_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   advance;
        ctype_t kind;
    } stk_op_t;

    function automatic ctype_t ct_advance(input ctype_t c);
        ctype_t r;
        r = c;
        if (c == CT_DKEY) begin
            r = CT_DVAL;
        end else if (c == CT_DVAL) begin
            r = CT_DKEY;
        end
        return r;
    endfunction

endpackage

// ===== rtl/bst_stack.sv =====
// Container stack: cached top entry over a synchronous memory for the entries below it.
module bst_stack import bst_pkg::*; #(
    parameter int MAX_DEPTH = 16,
    localparam int SW = $clog2(MAX_DEPTH + 1),
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  stk_op_t       op,
    output logic [SW-1:0] sp,
    output ctype_t        top,
    output ctype_t        below
);

    ctype_t        mem [MAX_DEPTH];
    logic [SW-1:0] sp_reg, sp_next;
    ctype_t        top_reg, top_next;
    ctype_t        rd_data_reg;
    ctype_t        fwd_data_reg;
    logic          fwd_reg;
    logic [SW-1:0] wr_full, rd_full;
    logic [IW-1:0] wr_addr, rd_addr;

    assign sp    = sp_reg;
    assign top   = top_reg;
    assign below = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb begin
        ctype_t t;
        sp_next = sp_reg;
        t       = top_reg;
        if (op.push) begin
            sp_next = sp_reg + SW'(1);
            t       = op.kind;
        end else if (op.pop) begin
            sp_next = sp_reg - SW'(1);
            t       = below;
        end
        if (op.advance) begin
            t = ct_advance(t);
        end
        top_next = t;
        wr_full  = sp_reg - SW'(1);
        rd_full  = sp_next - SW'(2);
        wr_addr  = wr_full[IW-1:0];
        rd_addr  = rd_full[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg  <= '0;
            fwd_reg <= 1'b0;
        end else begin
            sp_reg  <= sp_next;
            fwd_reg <= op.push;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        fwd_data_reg <= top_reg;
        rd_data_reg  <= mem[rd_addr];
        if (op.push && sp_reg != '0) begin
            mem[wr_addr] <= top_reg;
        end
    end

endmodule

// ===== rtl/bst_outq.sv =====
// Result queue: takes up to two results per cycle and hands them out one per transfer.
module bst_outq import bst_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic w0_valid,
    input  logic w1_valid,
    input  res_t w0,
    input  res_t w1,
    output logic space,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    res_t             q [OQ_DEPTH];
    logic [OQ_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [OQ_AW:0]   cnt_reg, cnt_next;
    logic             rd;
    logic [OQ_AW-1:0] wp1;

    assign m_valid = cnt_reg != '0;
    assign m_data  = q[rp_reg];
    assign space   = cnt_reg <= (OQ_AW + 1)'(OQ_DEPTH - 2);
    assign rd      = m_valid && m_ready;
    assign wp1     = wp_reg + OQ_AW'(1);

    always_comb begin
        wp_next  = wp_reg + OQ_AW'(w0_valid) + OQ_AW'(w1_valid);
        rp_next  = rp_reg + OQ_AW'(rd);
        cnt_next = cnt_reg + (OQ_AW + 1)'(w0_valid) + (OQ_AW + 1)'(w1_valid)
                   - (OQ_AW + 1)'(rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (w0_valid) begin
            q[wp_reg] <= w0;
        end
        if (w1_valid) begin
            q[wp1] <= w1;
        end
    end

endmodule

// ===== rtl/bst_core.sv =====
// Byte decoder: parse mode, position and length registers, stack commands and results.
module bst_core import bst_pkg::*; #(
    parameter int MAX_DEPTH     = 16,
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 32,
    localparam int SW = $clog2(MAX_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_eom,
    input  logic [SW-1:0] sp,
    input  ctype_t        top,
    input  ctype_t        below,
    output stk_op_t       op,
    output logic          r0_valid,
    output logic          r1_valid,
    output res_t          r0,
    output res_t          r1
);

    localparam int P = POSITION_BITS;
    localparam int L = LENGTH_BITS;
    localparam logic [L-1:0] LMAX = '1;

    mode_t          mode_reg, mode_next;
    logic [P-1:0]   pos_reg, pos_next, pos_inc;
    logic [P-1:0]   vstart_reg, vstart_next;
    logic [2:0]     flags_reg, flags_next;
    logic [L-1:0]   acc_reg, acc_next;
    logic [L-1:0]   rem_reg, rem_next, rem_dec;
    logic           err_reg;

    logic           active, digit, ovf, is_open, int_bad;
    logic [7:0]     dval;
    logic [L+3:0]   acc_x10;
    logic [L-1:0]   acc_inc;
    ctype_t         top_eff, chk_top;
    logic           sp_full;
    logic [SW-1:0]  sp_after;

    logic           tok_v, chk, err_v, done_hit, err_set;
    logic [2:0]     tok_kind;
    logic [P-1:0]   tok_off, err_at;
    logic [L-1:0]   tok_len;
    logic [3:0]     err_code;
    logic [2:0]     err_ctx;
    logic [4:0]     level;

    function automatic logic [31:0] pos32(input logic [P-1:0] v);
        logic [P+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    function automatic logic [31:0] len32(input logic [L-1:0] v);
        logic [L+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    function automatic logic [4:0] lvl5(input logic [SW-1:0] v);
        logic [SW+4:0] w;
        w = {5'd0, v};
        return w[4:0];
    endfunction

    assign active  = in_fire && !err_reg;
    assign digit   = in_byte >= CH_0 && in_byte <= CH_9;
    assign dval    = in_byte - CH_0;
    assign pos_inc = pos_reg + P'(1);
    assign top_eff = (sp != '0) ? top : CT_NONE;
    assign sp_full = sp >= SW'(MAX_DEPTH);
    assign is_open = in_byte == CH_L || in_byte == CH_D;
    assign acc_x10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + (L + 4)'(dval[3:0]);
    assign ovf     = |acc_x10[L+3:L];
    assign acc_inc = (acc_reg == LMAX) ? acc_reg : acc_reg + L'(1);
    assign rem_dec = (rem_reg == '0) ? rem_reg : rem_reg - L'(1);
    assign int_bad = (acc_reg == '0)
                     || (flags_reg[0] && acc_reg == L'(1))
                     || (flags_reg[0] && flags_reg[1])
                     || (!flags_reg[0] && flags_reg[1] && acc_reg > L'(1));

    always_comb begin
        tok_v       = 1'b0;
        tok_kind    = KIND_INT;
        tok_off     = pos_reg;
        tok_len     = '0;
        chk         = 1'b0;
        chk_top     = CT_LIST;
        sp_after    = sp;
        err_v       = 1'b0;
        err_code    = E_NONE;
        err_ctx     = CTX_NONE;
        err_at      = pos_reg;
        op          = '{push: 1'b0, pop: 1'b0, advance: 1'b0, kind: CT_LIST};
        vstart_next = vstart_reg;
        flags_next  = flags_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        if (active) begin
            unique case (mode_reg)
                MODE_EXPECT: begin
                    if (in_byte == CH_E && (top_eff == CT_LIST || top_eff == CT_DKEY)) begin
                        op.pop     = 1'b1;
                        op.advance = 1'b1;
                        sp_after   = sp - SW'(1);
                        tok_v      = 1'b1;
                        tok_kind   = (top_eff == CT_LIST) ? KIND_LCLOSE : KIND_DCLOSE;
                        chk        = 1'b1;
                        chk_top    = ct_advance(below);
                    end else if (top_eff == CT_DKEY && (in_byte == CH_I || is_open)) begin
                        err_v    = 1'b1;
                        err_code = E_KEY;
                        err_ctx  = CTX_DICT;
                    end else if (in_byte == CH_I) begin
                        vstart_next = pos_inc;
                        flags_next  = '0;
                        acc_next    = '0;
                        if (in_eom) begin
                            err_v    = 1'b1;
                            err_code = E_BAD_INT;
                            err_ctx  = CTX_INT;
                            err_at   = pos_inc;
                        end
                    end else if (is_open) begin
                        if (sp_full) begin
                            err_v    = 1'b1;
                            err_code = E_DEPTH;
                            err_ctx  = (in_byte == CH_L) ? CTX_LIST : CTX_DICT;
                        end else begin
                            op.push  = 1'b1;
                            op.kind  = (in_byte == CH_L) ? CT_LIST : CT_DKEY;
                            sp_after = sp + SW'(1);
                            tok_v    = 1'b1;
                            tok_kind = (in_byte == CH_L) ? KIND_LOPEN : KIND_DOPEN;
                            chk      = 1'b1;
                            chk_top  = op.kind;
                        end
                    end else if (digit) begin
                        acc_next = L'(dval[3:0]);
                        if (in_eom) begin
                            err_v    = 1'b1;
                            err_code = E_NO_COLON;
                            err_ctx  = CTX_STR;
                            err_at   = pos_inc;
                        end
                    end else begin
                        err_v    = 1'b1;
                        err_code = E_BAD_LEN;
                        err_ctx  = CTX_STR;
                    end
                end
                MODE_INT: begin
                    if (in_byte == CH_E) begin
                        if (int_bad) begin
                            err_v    = 1'b1;
                            err_code = E_BAD_INT;
                            err_ctx  = CTX_INT;
                            err_at   = pos_inc;
                        end else begin
                            tok_v      = 1'b1;
                            tok_kind   = KIND_INT;
                            tok_off    = vstart_reg;
                            tok_len    = acc_reg;
                            op.advance = 1'b1;
                            chk        = 1'b1;
                            chk_top    = ct_advance(top_eff);
                        end
                    end else if ((in_byte == CH_MINUS && acc_reg == '0) || digit) begin
                        if (in_byte == CH_MINUS) begin
                            flags_next[0] = 1'b1;
                        end else begin
                            if (!flags_reg[2] && in_byte == CH_0) begin
                                flags_next[1] = 1'b1;
                            end
                            flags_next[2] = 1'b1;
                        end
                        acc_next = acc_inc;
                        if (in_eom) begin
                            err_v    = 1'b1;
                            err_code = E_BAD_INT;
                            err_ctx  = CTX_INT;
                            err_at   = pos_inc;
                        end
                    end else begin
                        err_v    = 1'b1;
                        err_code = E_BAD_INT;
                        err_ctx  = CTX_INT;
                    end
                end
                MODE_STRLEN: begin
                    if (digit) begin
                        if (ovf) begin
                            err_v    = 1'b1;
                            err_code = E_LEN_OVF;
                            err_ctx  = CTX_STR;
                        end else begin
                            acc_next = acc_x10[L-1:0];
                            if (in_eom) begin
                                err_v    = 1'b1;
                                err_code = E_NO_COLON;
                                err_ctx  = CTX_STR;
                                err_at   = pos_inc;
                            end
                        end
                    end else if (in_byte == CH_COLON) begin
                        vstart_next = pos_inc;
                        if (acc_reg == '0) begin
                            tok_v      = 1'b1;
                            tok_kind   = KIND_STR;
                            tok_off    = pos_inc;
                            op.advance = 1'b1;
                            chk        = 1'b1;
                            chk_top    = ct_advance(top_eff);
                        end else if (in_eom) begin
                            err_v    = 1'b1;
                            err_code = E_BOUND;
                            err_ctx  = CTX_STR;
                            err_at   = pos_inc;
                        end else begin
                            rem_next = acc_reg;
                        end
                    end else begin
                        err_v    = 1'b1;
                        err_code = E_BAD_LEN;
                        err_ctx  = CTX_STR;
                    end
                end
                MODE_BODY: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        tok_v      = 1'b1;
                        tok_kind   = KIND_STR;
                        tok_off    = vstart_reg;
                        tok_len    = acc_reg;
                        op.advance = 1'b1;
                        chk        = 1'b1;
                        chk_top    = ct_advance(top_eff);
                    end else if (in_eom) begin
                        err_v    = 1'b1;
                        err_code = E_BOUND;
                        err_ctx  = CTX_STR;
                        err_at   = vstart_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign level = lvl5(sp_after);

    always_comb begin
        r0_valid = 1'b0;
        r1_valid = 1'b0;
        done_hit = 1'b0;
        err_set  = 1'b0;
        r0 = '{kind: tok_kind, code: E_NONE, ctx: CTX_NONE, offset: pos32(tok_off),
               length: len32(tok_len), level: level, last: 1'b1};
        r1 = '{kind: KIND_DONE, code: E_NONE, ctx: CTX_NONE, offset: pos32(pos_inc),
               length: 32'd0, level: level, last: 1'b1};
        if (sp_after != '0) begin
            r1.kind = KIND_ERROR;
            priority case (chk_top)
                CT_LIST: begin
                    r1.code = E_LIST_END;
                    r1.ctx  = CTX_LIST;
                end
                CT_DKEY: begin
                    r1.code = E_DICT_END;
                    r1.ctx  = CTX_DICT;
                end
                default: begin
                    r1.code = E_UNEXP_END;
                    r1.ctx  = CTX_DICT;
                end
            endcase
        end
        if (tok_v) begin
            r0_valid = 1'b1;
            if (chk && in_eom) begin
                r1_valid = 1'b1;
                r0.last  = 1'b0;
                done_hit = sp_after == '0;
                err_set  = sp_after != '0;
            end
        end else if (err_v) begin
            r0_valid  = 1'b1;
            err_set   = 1'b1;
            r0.kind   = KIND_ERROR;
            r0.code   = err_code;
            r0.ctx    = err_ctx;
            r0.offset = pos32(err_at);
            r0.length = 32'd0;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        if (active) begin
            unique case (mode_reg)
                MODE_EXPECT: begin
                    if (in_byte == CH_I && top_eff != CT_DKEY) begin
                        mode_next = MODE_INT;
                    end else if (digit) begin
                        mode_next = MODE_STRLEN;
                    end
                end
                MODE_INT: begin
                    if (in_byte == CH_E) begin
                        mode_next = MODE_EXPECT;
                    end
                end
                MODE_STRLEN: begin
                    if (in_byte == CH_COLON) begin
                        mode_next = (acc_reg == '0) ? MODE_EXPECT : MODE_BODY;
                    end
                end
                MODE_BODY: begin
                    if (rem_dec == '0) begin
                        mode_next = MODE_EXPECT;
                    end
                end
                default: begin
                    mode_next = MODE_EXPECT;
                end
            endcase
            if (done_hit) begin
                mode_next = MODE_EXPECT;
            end
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (active) begin
            pos_next = done_hit ? '0 : pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_EXPECT;
            pos_reg  <= '0;
            err_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            err_reg  <= err_reg || err_set;
        end
    end

    always_ff @(posedge aclk) begin
        vstart_reg <= vstart_next;
        flags_reg  <= flags_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
    end

endmodule

// ===== rtl/bencode_stream_tokenizer_unit.sv =====
// Top level of the bencode stream tokenizer: stream ports, decoder, stack and result queue.
//
// Accepts one message byte per cycle and emits integer, string, list and dictionary
// tokens, then a done token (or one error token, after which all further bytes are
// dropped until reset). A byte yields zero, one or two results; they pass through a
// four-entry result queue, and s_tready is low only while that queue cannot take two
// more, so a byte is taken every cycle as long as results are drained. Each byte makes
// one read-modify-write of the container stack: the top entry sits in a register and
// the entries below it in a memory with a registered read, kept one entry ahead so a
// close is served in the same cycle. The stack memory needs no clearing after reset.
module bencode_stream_tokenizer_unit import bst_pkg::*; #(
    parameter int MAX_DEPTH     = 16,
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // [3:0] error_code, [6:4] error_context,
                                  // [38:7] token_offset, [70:39] token_length,
                                  // [75:71] nesting_level, [79:76] zero
    output logic [2:0]  m_tuser,  // [2:0] token_kind
    output logic        m_tlast
);

    localparam int SW = $clog2(MAX_DEPTH + 1);

    logic          in_fire;
    logic [SW-1:0] sp;
    ctype_t        top, below;
    stk_op_t       op;
    logic          r0_valid, r1_valid;
    res_t          r0, r1, q_data;

    assign in_fire = s_tvalid && s_tready;

    bst_core #(
        .MAX_DEPTH     (MAX_DEPTH),
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_byte  (s_tdata),
        .in_eom   (s_tlast),
        .sp       (sp),
        .top      (top),
        .below    (below),
        .op       (op),
        .r0_valid (r0_valid),
        .r1_valid (r1_valid),
        .r0       (r0),
        .r1       (r1)
    );

    bst_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .sp      (sp),
        .top     (top),
        .below   (below)
    );

    bst_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .w0_valid (r0_valid),
        .w1_valid (r1_valid),
        .w0       (r0),
        .w1       (r1),
        .space    (s_tready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (q_data)
    );

    assign m_tdata = {4'd0, q_data.level, q_data.length, q_data.offset, q_data.ctx, q_data.code};
    assign m_tuser = q_data.kind;
    assign m_tlast = q_data.last;

endmodule

// ===== verif/bencode_stream_tokenizer_unit_tb.sv =====
// Testbench for the bencode stream tokenizer: token predictor, scoreboard and random streams.
module bencode_stream_tokenizer_unit_tb;
    import bst_pkg::*;

    localparam int TB_DEPTH = 16;
    localparam int HOLD_AT  = 250;
    localparam int HOLD_LEN = 100;

    class token_scoreboard;
        mode_t       mode;
        logic [31:0] pos;
        logic [31:0] vstart;
        logic [31:0] acc;
        logic [31:0] remain;
        logic [2:0]  iflags;
        ctype_t      frames[TB_DEPTH];
        int          depth;
        bit          halted;
        int          step_n;
        res_t        pending_tokens[$];
        int          mismatches;
        int          tokens_checked;
        int          bytes_seen;
        int          kind_seen[8];
        int          error_code_seen;

        function new();
            mode = MODE_EXPECT;
            pos = '0;
            vstart = '0;
            acc = '0;
            remain = '0;
            iflags = '0;
            foreach (frames[i]) frames[i] = CT_LIST;
            depth = 0;
            halted = 1'b0;
            mismatches = 0;
            tokens_checked = 0;
            bytes_seen = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
            error_code_seen = -1;
        endfunction

        function void push_token(logic [2:0] kind, logic [3:0] code, logic [2:0] ctx,
                                 logic [31:0] off, logic [31:0] len);
            res_t t;
            if (step_n >= 2) return;
            t.kind = kind;
            t.code = code;
            t.ctx = ctx;
            t.offset = off;
            t.length = len;
            t.level = 5'(depth);
            t.last = 1'b0;
            pending_tokens = {pending_tokens, t};
            step_n++;
        endfunction

        function void fail(logic [3:0] code, logic [2:0] ctx, logic [31:0] at);
            push_token(KIND_ERROR, code, ctx, at, '0);
            halted = 1'b1;
        endfunction

        function bit end_check(bit last, logic [31:0] nxt);
            ctype_t top;
            if (!last) return 1'b0;
            if (depth == 0) begin
                push_token(KIND_DONE, E_NONE, CTX_NONE, nxt, '0);
                return 1'b1;
            end
            top = frames[depth - 1];
            if (top == CT_LIST) begin
                fail(E_LIST_END, CTX_LIST, nxt);
            end else if (top == CT_DKEY) begin
                fail(E_DICT_END, CTX_DICT, nxt);
            end else begin
                fail(E_UNEXP_END, CTX_DICT, nxt);
            end
            return 1'b0;
        endfunction

        function bit element_done(bit last, logic [31:0] nxt);
            if (depth > 0) begin
                if (frames[depth - 1] == CT_DKEY) begin
                    frames[depth - 1] = CT_DVAL;
                end else if (frames[depth - 1] == CT_DVAL) begin
                    frames[depth - 1] = CT_DKEY;
                end
            end
            return end_check(last, nxt);
        endfunction

        // advance the tokenizer state by one accepted byte and queue the tokens it yields
        function void predict_tokens(logic [7:0] b, bit last);
            logic [31:0] nxt;
            logic [31:0] d;
            ctype_t      top;
            bit          fin;
            bit          dig;
            bit          bad;
            bit          neg;
            bit          fz;
            step_n = 0;
            bytes_seen++;
            if (halted) return;
            nxt = pos + 32'd1;
            dig = (b >= CH_0) && (b <= CH_9);
            fin = 1'b0;
            case (mode)
                MODE_EXPECT: begin
                    top = (depth > 0) ? frames[depth - 1] : CT_NONE;
                    if (b == CH_E && (top == CT_LIST || top == CT_DKEY)) begin
                        depth--;
                        push_token((top == CT_LIST) ? KIND_LCLOSE : KIND_DCLOSE,
                                   E_NONE, CTX_NONE, pos, '0);
                        fin = element_done(last, nxt);
                    end else if (top == CT_DKEY && (b == CH_I || b == CH_L || b == CH_D)) begin
                        fail(E_KEY, CTX_DICT, pos);
                    end else if (b == CH_I) begin
                        vstart = nxt;
                        iflags = '0;
                        acc = '0;
                        mode = MODE_INT;
                        if (last) fail(E_BAD_INT, CTX_INT, nxt);
                    end else if (b == CH_L || b == CH_D) begin
                        if (depth >= TB_DEPTH) begin
                            fail(E_DEPTH, (b == CH_L) ? CTX_LIST : CTX_DICT, pos);
                        end else begin
                            frames[depth] = (b == CH_L) ? CT_LIST : CT_DKEY;
                            depth++;
                            push_token((b == CH_L) ? KIND_LOPEN : KIND_DOPEN,
                                       E_NONE, CTX_NONE, pos, '0);
                            fin = end_check(last, nxt);
                        end
                    end else if (dig) begin
                        acc = 32'(b - CH_0);
                        mode = MODE_STRLEN;
                        if (last) fail(E_NO_COLON, CTX_STR, nxt);
                    end else begin
                        fail(E_BAD_LEN, CTX_STR, pos);
                    end
                end
                MODE_INT: begin
                    if (b == CH_E) begin
                        neg = iflags[0];
                        fz = iflags[1];
                        bad = (acc == 0) || (neg && acc == 1) || (neg && fz) ||
                              (!neg && fz && acc > 1);
                        mode = MODE_EXPECT;
                        if (bad) begin
                            fail(E_BAD_INT, CTX_INT, nxt);
                        end else begin
                            push_token(KIND_INT, E_NONE, CTX_NONE, vstart, acc);
                            fin = element_done(last, nxt);
                        end
                    end else if ((b == CH_MINUS && acc == 0) || dig) begin
                        if (b == CH_MINUS) begin
                            iflags[0] = 1'b1;
                        end else begin
                            if (!iflags[2] && b == CH_0) iflags[1] = 1'b1;
                            iflags[2] = 1'b1;
                        end
                        if (acc != '1) acc++;
                        if (last) fail(E_BAD_INT, CTX_INT, nxt);
                    end else begin
                        fail(E_BAD_INT, CTX_INT, pos);
                    end
                end
                MODE_STRLEN: begin
                    if (dig) begin
                        d = 32'(b - CH_0);
                        if (acc > (32'hFFFF_FFFF - d) / 32'd10) begin
                            fail(E_LEN_OVF, CTX_STR, pos);
                        end else begin
                            acc = acc * 32'd10 + d;
                            if (last) fail(E_NO_COLON, CTX_STR, nxt);
                        end
                    end else if (b == CH_COLON) begin
                        vstart = nxt;
                        if (acc == 0) begin
                            mode = MODE_EXPECT;
                            push_token(KIND_STR, E_NONE, CTX_NONE, nxt, '0);
                            fin = element_done(last, nxt);
                        end else if (last) begin
                            fail(E_BOUND, CTX_STR, nxt);
                        end else begin
                            remain = acc;
                            mode = MODE_BODY;
                        end
                    end else begin
                        fail(E_BAD_LEN, CTX_STR, pos);
                    end
                end
                MODE_BODY: begin
                    if (remain > 0) remain--;
                    if (remain == 0) begin
                        mode = MODE_EXPECT;
                        push_token(KIND_STR, E_NONE, CTX_NONE, vstart, acc);
                        fin = element_done(last, nxt);
                    end else if (last) begin
                        fail(E_BOUND, CTX_STR, vstart);
                    end
                end
            endcase
            if (fin) begin
                pos = '0;
                mode = MODE_EXPECT;
            end else begin
                pos = nxt;
            end
            if (step_n > 0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
        endfunction

        function void check_token(logic [2:0] kind, logic [79:0] data, logic last);
            res_t want;
            bit   bad;
            if (pending_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d data %h last %0b", kind, data, last);
                return;
            end
            want = pending_tokens.pop_front();
            bad = (kind !== want.kind) || (data[3:0] !== want.code) ||
                  (data[6:4] !== want.ctx) || (data[38:7] !== want.offset) ||
                  (data[70:39] !== want.length) || (data[75:71] !== want.level) ||
                  (data[79:76] !== 4'h0) || (last !== want.last);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("token %0d expected: kind %0d code %0d ctx %0d",
                             tokens_checked, want.kind, want.code, want.ctx);
                    $display("    off %0d len %0d lvl %0d last %0b",
                             want.offset, want.length, want.level, want.last);
                    $display("token %0d actual:   kind %0d code %0d ctx %0d",
                             tokens_checked, kind, data[3:0], data[6:4]);
                    $display("    off %0d len %0d lvl %0d last %0b pad %h",
                             data[38:7], data[70:39], data[75:71], last, data[79:76]);
                end
            end
            if (want.kind == KIND_ERROR) error_code_seen = want.code;
            kind_seen[want.kind]++;
            tokens_checked++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard board;
    logic [7:0]      msg_q[$];
    int              burst_left = 0;

    bencode_stream_tokenizer_unit #(
        .MAX_DEPTH     (TB_DEPTH),
        .POSITION_BITS (32),
        .LENGTH_BITS   (32)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready) board.predict_tokens(s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_token(m_tuser, m_tdata, m_tlast);
        end
    end

    initial begin : drain
        int cyc;
        int seg_left;
        int style;
        m_tready = 1'b0;
        cyc = 0;
        seg_left = 0;
        style = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                style = $urandom_range(0, 3);
            end
            seg_left--;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((cyc % 3) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void put_byte(logic [7:0] b);
        msg_q = {msg_q, b};
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_int();
        int n;
        put_byte(CH_I);
        if ($urandom_range(0, 4) == 0) begin
            put_byte(CH_0);
        end else begin
            if ($urandom_range(0, 1)) put_byte(CH_MINUS);
            put_byte(8'(CH_0 + $urandom_range(1, 9)));
            n = $urandom_range(0, 8);
            repeat (n) put_byte(8'(CH_0 + $urandom_range(0, 9)));
        end
        put_byte(CH_E);
    endfunction

    function automatic void put_str();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0) put_byte(CH_0);
        put_text($sformatf("%0d", len));
        put_byte(CH_COLON);
        repeat (len) put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_value(int lvl);
        int pick;
        int n;
        pick = (lvl >= 5) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        n = $urandom_range(0, 3);
        case (pick)
            0: put_int();
            1: put_str();
            2: begin
                put_byte(CH_L);
                repeat (n) put_value(lvl + 1);
                put_byte(CH_E);
            end
            default: begin
                put_byte(CH_D);
                repeat (n) begin
                    put_str();
                    put_value(lvl + 1);
                end
                put_byte(CH_E);
            end
        endcase
    endfunction

    function automatic void put_broken_tail();
        case ($urandom_range(0, 17))
            0: put_text("ie");
            1: put_text("i-e");
            2: put_text("i-0e");
            3: put_text("i03e");
            4: put_text("i1x");
            5: put_text("li12");
            6: put_text("x");
            7: put_text(":");
            8: put_text("e");
            9: put_text("3x");
            10: put_text("d12");
            11: put_text("4294967296");
            12: put_text("l5:ab");
            13: put_text("di1ee");
            14: put_text("li1e");
            15: put_text("d1:ai1e");
            16: put_text("d1:a");
            default: repeat (TB_DEPTH + 1) put_byte(CH_D);
        endcase
    endfunction

    // enter at a falling edge, return at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_msg();
        int n;
        n = msg_q.size();
        for (int i = 0; i < n; i++) send_byte(msg_q[i], i == n - 1);
        msg_q.delete();
    endtask

    initial begin : stimulus
        int random_bytes;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        board = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        put_text("i0e");
        send_msg();
        put_text("i-42ei1234567890e");
        send_msg();
        put_text("0:");
        send_msg();
        put_text("4:");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h55);
        put_byte(8'hAA);
        send_msg();
        put_text("lede");
        send_msg();
        put_text("d3:keyli-7ee0:dee");
        send_msg();
        put_text("003:abc");
        send_msg();
        repeat (TB_DEPTH / 2) put_text("ld1:k");
        put_text("i9e");
        repeat (TB_DEPTH / 2) put_text("ee");
        send_msg();

        random_bytes = 0;
        while (random_bytes < 260) begin
            repeat ($urandom_range(1, 2)) put_value(0);
            random_bytes += msg_q.size();
            send_msg();
        end

        put_broken_tail();
        send_msg();
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;

        while (board.pending_tokens.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("run covered %0d bytes and %0d tokens: int %0d str %0d lopen %0d lclose %0d",
                 board.bytes_seen, board.tokens_checked, board.kind_seen[KIND_INT],
                 board.kind_seen[KIND_STR], board.kind_seen[KIND_LOPEN],
                 board.kind_seen[KIND_LCLOSE]);
        $display("dopen %0d dclose %0d done %0d, closing error code %0d, mismatches %0d",
                 board.kind_seen[KIND_DOPEN], board.kind_seen[KIND_DCLOSE],
                 board.kind_seen[KIND_DONE], board.error_code_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending_tokens.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
